FILE: src/htlp_pkg.sv
package htlp_pkg;
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_OCC   = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_LOOKUP = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;

  localparam logic [1:0] RS_OK   = 2'd0;
  localparam logic [1:0] RS_NF   = 2'd1;
  localparam logic [1:0] RS_DUP  = 2'd2;
  localparam logic [1:0] RS_FULL = 2'd3;

  localparam logic CFG_SET_MODE  = 1'b0;
  localparam logic CFG_KEY_BYTES = 1'b1;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int MIX_SHIFT = 33;

  typedef logic [1:0] status_t;

  function automatic logic [63:0] key_mask(input logic [3:0] kb);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (kb > 4'(b)) m[8*b +: 8] = 8'hff;
    end
    return m;
  endfunction
endpackage

FILE: src/htlp_ram.sv
module htlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/hash_table_linear_probe_core.sv
// After reset a clear pass over every slot empties the slot store (start ignored, busy high).
// Per request: hash (one shared 32x32 multiplier, 6 partial products), then per probed slot
// a slot memory read, then a check, then a done state to answer; out_valid is registered from it.
// A new request is accepted only when idle, after the last one is answered; at most CAPACITY
// slots are probed. busy drops with out_valid; no result stall. Synchronous active-low reset
// sets config defaults and clears counts; slot state is cleared via the clear pass.
module hash_table_linear_probe_core #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_func,
  input  logic [63:0]           in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [63:0]           out_found_value,
  output logic [10:0]           out_entry_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [3:0]            cfg_data
);
  import htlp_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MIX  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_DONE = 4'd5;

  logic [3:0]  state_r, state_nxt;
  logic        set_mode_r;
  logic [3:0]  key_bytes_r;
  logic [1:0]  func_r;
  logic [63:0] key_r, mask_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [63:0] x_r, acc_r;
  logic [2:0]  mstep_r;
  logic [1:0]  mphase_r;
  logic [AW-1:0] slot_r;
  logic [CW-1:0] probes_r;
  logic        have_tomb_r;
  logic [AW-1:0] tomb_r;
  logic [CW-1:0] occ_r;
  status_t     status_r;
  logic [63:0] found_r;
  logic        outv_r;

  logic        st_we, kv_we, key_we;
  logic [AW-1:0] st_wa, kv_wa;
  logic [1:0]  st_wd, st_rd;
  logic [63:0] key_rd;
  logic [VALUE_BITS-1:0] kv_val_wd, val_rd;

  htlp_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_st (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(slot_r), .rdata(st_rd));
  htlp_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(key_we), .waddr(kv_wa), .wdata(key_r), .raddr(slot_r), .rdata(key_rd));
  htlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .we(kv_we), .waddr(kv_wa), .wdata(kv_val_wd), .raddr(slot_r),
    .rdata(val_rd));

  // shared 32x32 multiplier, 64-bit product mod 2^64 built from 3 partial products
  logic [31:0] ma, mb;
  logic [63:0] mprod;
  logic [63:0] cmul;
  assign cmul = (mstep_r[2]) ? MIX_C2 : MIX_C1;
  always_comb begin
    ma = x_r[31:0];
    mb = cmul[31:0];
    case (mphase_r)
      2'd1: begin ma = x_r[63:32]; mb = cmul[31:0]; end
      2'd2: begin ma = x_r[31:0]; mb = cmul[63:32]; end
      default: begin ma = x_r[31:0]; mb = cmul[31:0]; end
    endcase
  end
  assign mprod = 64'(ma) * 64'(mb);

  logic match, full_hit;
  assign match = (st_rd == ST_OCC) && ((key_rd & mask_r) == key_r);
  assign full_hit = (probes_r == CW'(CAPACITY - 1));

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = outv_r;
  assign out_status = status_r;
  assign out_found_value = found_r;
  assign out_entry_total = 11'(occ_r);

  always_comb begin
    state_nxt = state_r;
    st_we = 1'b0;
    st_wa = slot_r;
    st_wd = ST_OCC;
    kv_we = 1'b0;
    key_we = 1'b0;
    kv_wa = slot_r;
    kv_val_wd = set_mode_r ? '0 : val_r;
    case (state_r)
      S_CLR: begin
        st_we = 1'b1;
        st_wd = ST_EMPTY;
        if (slot_r == AW'(CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (start) state_nxt = S_MIX;
      S_MIX: if (mstep_r == 3'd5 && mphase_r == 2'd0) state_nxt = S_RD;
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        state_nxt = S_RD;
        if (func_r == FN_INSERT) begin
          if (st_rd == ST_EMPTY) begin
            st_we = 1'b1; kv_we = 1'b1; key_we = 1'b1;
            st_wa = have_tomb_r ? tomb_r : slot_r;
            kv_wa = st_wa;
            state_nxt = S_DONE;
          end else if (match) begin
            if (!set_mode_r) begin kv_we = 1'b1; end
            state_nxt = S_DONE;
          end else if (full_hit) begin
            if (have_tomb_r || st_rd == ST_TOMB) begin
              st_we = 1'b1; kv_we = 1'b1; key_we = 1'b1;
              st_wa = have_tomb_r ? tomb_r : slot_r;
              kv_wa = st_wa;
            end
            state_nxt = S_DONE;
          end
        end else if (func_r == FN_LOOKUP || func_r == FN_REMOVE) begin
          if (st_rd == ST_EMPTY || full_hit) state_nxt = S_DONE;
          if (match) begin
            state_nxt = S_DONE;
            if (func_r == FN_REMOVE) begin st_we = 1'b1; st_wd = ST_TOMB; end
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      slot_r <= '0;
      set_mode_r <= 1'b0;
      key_bytes_r <= 4'd8;
      occ_r <= '0;
      outv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r <= (state_r == S_DONE);
      if (cfg_valid) begin
        if (cfg_index == CFG_SET_MODE) set_mode_r <= cfg_data[0];
        else key_bytes_r <= cfg_data;
      end
      case (state_r)
        S_CLR: slot_r <= slot_r + 1'b1;
        S_IDLE: begin
          if (start) begin
            func_r <= in_func;
            mask_r <= key_mask(key_bytes_r);
            key_r <= in_key & key_mask(key_bytes_r);
            x_r <= in_key & key_mask(key_bytes_r);
            val_r <= in_value;
            mstep_r <= '0;
            mphase_r <= '0;
            have_tomb_r <= 1'b0;
            probes_r <= '0;
            status_r <= RS_NF;
            found_r <= '0;
          end
        end
        S_MIX: begin
          // steps: 0 xorshift, 1 mul C1, 2 xorshift, 4 mul C2 (bit2), 5 xorshift to slot
          case (mstep_r)
            3'd0, 3'd2: begin
              x_r <= x_r ^ (x_r >> MIX_SHIFT);
              mstep_r <= (mstep_r == 3'd0) ? 3'd1 : 3'd4;
            end
            3'd1, 3'd4: begin
              if (mphase_r == 2'd0) begin acc_r <= mprod; mphase_r <= 2'd1; end
              else if (mphase_r == 2'd1) begin
                acc_r <= acc_r + {mprod[31:0], 32'd0}; mphase_r <= 2'd2;
              end else begin
                x_r <= acc_r + {mprod[31:0], 32'd0};
                mphase_r <= 2'd0;
                mstep_r <= (mstep_r == 3'd1) ? 3'd2 : 3'd5;
              end
            end
            default: begin
              slot_r <= AW'(x_r ^ (x_r >> MIX_SHIFT));
            end
          endcase
        end
        S_CHK: begin
          if (st_rd == ST_TOMB && !have_tomb_r) begin
            have_tomb_r <= 1'b1; tomb_r <= slot_r;
          end
          probes_r <= probes_r + 1'b1;
          slot_r <= slot_r + 1'b1;
          if (func_r == FN_INSERT) begin
            if (st_rd == ST_EMPTY) begin
              status_r <= RS_OK; occ_r <= occ_r + 1'b1;
            end else if (match) begin
              status_r <= set_mode_r ? RS_DUP : RS_OK;
            end else if (full_hit) begin
              if (have_tomb_r || st_rd == ST_TOMB) begin
                status_r <= RS_OK; occ_r <= occ_r + 1'b1;
              end else status_r <= RS_FULL;
            end
          end else if (match && (func_r == FN_LOOKUP || func_r == FN_REMOVE)) begin
            status_r <= RS_OK;
            if (func_r == FN_LOOKUP) found_r <= set_mode_r ? '0 : 64'(val_rd);
            else occ_r <= occ_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
